>>> src/odsc_pkg.sv
// ----------------------------------------------------------------------------
// odsc_pkg
// Shared constants and types for the online distinct substring counter.
// ----------------------------------------------------------------------------
package odsc_pkg;

    localparam int MAX_CHARS = 4096;
    localparam int ALPHA     = 26;
    localparam int NODE_CAP  = 2 * MAX_CHARS;
    localparam int NODE_W    = $clog2(NODE_CAP);
    localparam int HELD_W    = $clog2(MAX_CHARS + 1);
    localparam int TR_DEPTH  = NODE_CAP * ALPHA;
    localparam int TR_AW     = $clog2(TR_DEPTH);
    localparam int IDX_W     = $clog2(ALPHA);
    localparam int COUNT_W   = 24;
    localparam int ACT_W     = 2;
    localparam int LET_W     = 5;

    typedef enum logic [ACT_W-1:0] {
        ACT_APPEND  = 2'd0,
        ACT_QUERY   = 2'd1,
        ACT_RESTART = 2'd2,
        ACT_NONE    = 2'd3
    } action_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_NEW,
        S_CLR,
        S_WRD,
        S_WCHK,
        S_FND0,
        S_FND1,
        S_FND2,
        S_CPRD,
        S_CPWR,
        S_CLK1,
        S_CLK2,
        S_RRD,
        S_RCHK,
        S_FIN0,
        S_FIN1
    } state_t;

endpackage

>>> src/odsc_ram.sv
// ----------------------------------------------------------------------------
// odsc_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module odsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> src/online_distinct_substring_counter_unit.sv
// ----------------------------------------------------------------------------
// online_distinct_substring_counter_unit
// Suffix automaton over a letter stream; a query returns the count of
// distinct substrings, strobed on done in the cycle after the transfer.
// Append keeps busy high through the row clear of the new node and the link
// walk, plus the checks when the walk stops on an existing edge, plus the row
// copy and the redirect walk when a node is cloned (the row clear and copy
// step one entry at a time through the transition memory, which shares one
// address for read and write). Restart keeps busy high while the root row is
// cleared, and so does reset. Results cannot be stalled.
// ----------------------------------------------------------------------------
module online_distinct_substring_counter_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [odsc_pkg::ACT_W-1:0]    action,
    input  logic [odsc_pkg::LET_W-1:0]    letter,
    output logic                          done,
    output logic [odsc_pkg::COUNT_W-1:0]  distinct_count,
    output logic                          dropped
);

    localparam int NW = odsc_pkg::NODE_W;
    localparam int IW = odsc_pkg::IDX_W;
    localparam int AW = odsc_pkg::TR_AW;
    localparam logic [odsc_pkg::LET_W-1:0] LET_ALPHA = odsc_pkg::LET_W'(odsc_pkg::ALPHA);

    odsc_pkg::state_t state_reg, state_next;

    logic [NW-1:0] total_reg, total_next;
    logic [NW-1:0] last_reg, last_next;
    logic [NW-1:0] cur_reg, cur_next;
    logic [NW-1:0] p_reg, p_next;
    logic [NW-1:0] q_reg, q_next;
    logic [NW-1:0] cl_reg, cl_next;
    logic [NW-1:0] clr_node_reg, clr_node_next;
    logic [NW-1:0] linkcur_reg, linkcur_next;
    logic [NW-1:0] linkq_reg, linkq_next;
    logic [NW-1:0] lencur_reg, lencur_next;
    logic [NW-1:0] lenp_reg, lenp_next;
    logic [IW-1:0] ch_reg, ch_next;
    logic [IW-1:0] cnt_reg, cnt_next;
    logic          ret_walk_reg, ret_walk_next;
    logic [odsc_pkg::HELD_W-1:0]  held_reg, held_next;
    logic [odsc_pkg::COUNT_W-1:0] sum_reg, sum_next;
    logic          ovf_reg, ovf_next;
    logic          done_reg, done_next;
    logic [odsc_pkg::COUNT_W-1:0] dcount_reg, dcount_next;
    logic          dropped_reg, dropped_next;

    // memory ports
    logic          len_we;
    logic [NW-1:0] len_waddr, len_wdata, len_raddr, len_rdata;
    logic          link_we;
    logic [NW-1:0] link_waddr, link_wdata, link_raddr, link_rdata;
    logic          tr_we;
    logic [NW-1:0] tr_wdata, tr_rdata;
    logic [NW-1:0] tr_node;
    logic [IW-1:0] tr_idx;
    logic [AW-1:0] tr_addr;

    logic accept;

    odsc_ram #(.WIDTH(NW), .DEPTH(odsc_pkg::NODE_CAP)) u_len (
        .clk(clk), .we(len_we), .waddr(len_waddr), .wdata(len_wdata),
        .raddr(len_raddr), .rdata(len_rdata)
    );

    odsc_ram #(.WIDTH(NW), .DEPTH(odsc_pkg::NODE_CAP)) u_link (
        .clk(clk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
        .raddr(link_raddr), .rdata(link_rdata)
    );

    odsc_ram #(.WIDTH(NW), .DEPTH(odsc_pkg::TR_DEPTH)) u_trans (
        .clk(clk), .we(tr_we), .waddr(tr_addr), .wdata(tr_wdata),
        .raddr(tr_addr), .rdata(tr_rdata)
    );

    // shared row address unit: node * ALPHA + index
    assign tr_addr = AW'(tr_node) * AW'(odsc_pkg::ALPHA) + AW'(tr_idx);

    assign busy           = (state_reg != odsc_pkg::S_IDLE);
    assign accept         = start && !busy;
    assign done           = done_reg;
    assign distinct_count = dcount_reg;
    assign dropped        = dropped_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= odsc_pkg::S_CLR;
            total_reg    <= NW'(1);
            last_reg     <= '0;
            clr_node_reg <= '0;
            cnt_reg      <= '0;
            ret_walk_reg <= 1'b0;
            held_reg     <= '0;
            sum_reg      <= '0;
            ovf_reg      <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            total_reg    <= total_next;
            last_reg     <= last_next;
            clr_node_reg <= clr_node_next;
            cnt_reg      <= cnt_next;
            ret_walk_reg <= ret_walk_next;
            held_reg     <= held_next;
            sum_reg      <= sum_next;
            ovf_reg      <= ovf_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg     <= cur_next;
        p_reg       <= p_next;
        q_reg       <= q_next;
        cl_reg      <= cl_next;
        linkcur_reg <= linkcur_next;
        linkq_reg   <= linkq_next;
        lencur_reg  <= lencur_next;
        lenp_reg    <= lenp_next;
        ch_reg      <= ch_next;
        dcount_reg  <= dcount_next;
        dropped_reg <= dropped_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        total_next    = total_reg;
        last_next     = last_reg;
        cur_next      = cur_reg;
        p_next        = p_reg;
        q_next        = q_reg;
        cl_next       = cl_reg;
        clr_node_next = clr_node_reg;
        linkcur_next  = linkcur_reg;
        linkq_next    = linkq_reg;
        lencur_next   = lencur_reg;
        lenp_next     = lenp_reg;
        ch_next       = ch_reg;
        cnt_next      = cnt_reg;
        ret_walk_next = ret_walk_reg;
        held_next     = held_reg;
        sum_next      = sum_reg;
        ovf_next      = ovf_reg;
        done_next     = 1'b0;
        dcount_next   = dcount_reg;
        dropped_next  = dropped_reg;

        len_we     = 1'b0;
        len_waddr  = total_reg;
        len_wdata  = len_rdata + NW'(1);
        len_raddr  = last_reg;
        link_we    = 1'b0;
        link_waddr = cur_reg;
        link_wdata = linkcur_reg;
        link_raddr = p_reg;
        tr_we      = 1'b0;
        tr_wdata   = '0;
        tr_node    = p_reg;
        tr_idx     = ch_reg;

        case (state_reg)
            odsc_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    case (action)
                        odsc_pkg::ACT_APPEND:
                        begin
                            if (letter < LET_ALPHA)
                            begin
                                if (held_reg >= odsc_pkg::HELD_W'(odsc_pkg::MAX_CHARS))
                                begin
                                    ovf_next = 1'b1;
                                end
                                else
                                begin
                                    ch_next    = IW'(letter);
                                    state_next = odsc_pkg::S_NEW;
                                end
                            end
                        end
                        odsc_pkg::ACT_QUERY:
                        begin
                            done_next    = 1'b1;
                            dcount_next  = sum_reg;
                            dropped_next = ovf_reg;
                        end
                        odsc_pkg::ACT_RESTART:
                        begin
                            total_next    = NW'(1);
                            last_next     = '0;
                            sum_next      = '0;
                            held_next     = '0;
                            ovf_next      = 1'b0;
                            clr_node_next = '0;
                            cnt_next      = '0;
                            ret_walk_next = 1'b0;
                            state_next    = odsc_pkg::S_CLR;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            // len[last] is on the read port; create the new node
            odsc_pkg::S_NEW:
            begin
                len_we        = 1'b1;
                lencur_next   = len_rdata + NW'(1);
                cur_next      = total_reg;
                total_next    = total_reg + NW'(1);
                p_next        = last_reg;
                clr_node_next = total_reg;
                cnt_next      = '0;
                ret_walk_next = 1'b1;
                state_next    = odsc_pkg::S_CLR;
            end

            odsc_pkg::S_CLR:
            begin
                tr_node  = clr_node_reg;
                tr_idx   = cnt_reg;
                tr_we    = 1'b1;
                tr_wdata = '0;
                if (clr_node_reg == '0 && cnt_reg == '0)
                begin
                    // root length is zero
                    len_we    = 1'b1;
                    len_waddr = '0;
                    len_wdata = '0;
                end
                if (cnt_reg == IW'(odsc_pkg::ALPHA - 1))
                begin
                    state_next = ret_walk_reg ? odsc_pkg::S_WRD : odsc_pkg::S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + IW'(1);
                end
            end

            odsc_pkg::S_WRD:
            begin
                state_next = odsc_pkg::S_WCHK;
            end

            odsc_pkg::S_WCHK:
            begin
                if (tr_rdata != '0)
                begin
                    q_next     = tr_rdata;
                    state_next = odsc_pkg::S_FND0;
                end
                else
                begin
                    tr_we    = 1'b1;
                    tr_wdata = cur_reg;
                    if (p_reg == '0)
                    begin
                        linkcur_next = '0;
                        state_next   = odsc_pkg::S_FIN0;
                    end
                    else
                    begin
                        p_next     = link_rdata;
                        state_next = odsc_pkg::S_WRD;
                    end
                end
            end

            odsc_pkg::S_FND0:
            begin
                len_raddr  = p_reg;
                state_next = odsc_pkg::S_FND1;
            end

            odsc_pkg::S_FND1:
            begin
                lenp_next  = len_rdata;
                len_raddr  = q_reg;
                link_raddr = q_reg;
                state_next = odsc_pkg::S_FND2;
            end

            odsc_pkg::S_FND2:
            begin
                linkq_next = link_rdata;
                if (lenp_reg + NW'(1) == len_rdata)
                begin
                    linkcur_next = q_reg;
                    state_next   = odsc_pkg::S_FIN0;
                end
                else
                begin
                    len_we     = 1'b1;
                    len_wdata  = lenp_reg + NW'(1);
                    cl_next    = total_reg;
                    total_next = total_reg + NW'(1);
                    cnt_next   = '0;
                    state_next = odsc_pkg::S_CPRD;
                end
            end

            odsc_pkg::S_CPRD:
            begin
                tr_node    = q_reg;
                tr_idx     = cnt_reg;
                state_next = odsc_pkg::S_CPWR;
            end

            odsc_pkg::S_CPWR:
            begin
                tr_node  = cl_reg;
                tr_idx   = cnt_reg;
                tr_we    = 1'b1;
                tr_wdata = tr_rdata;
                if (cnt_reg == IW'(odsc_pkg::ALPHA - 1))
                begin
                    state_next = odsc_pkg::S_CLK1;
                end
                else
                begin
                    cnt_next   = cnt_reg + IW'(1);
                    state_next = odsc_pkg::S_CPRD;
                end
            end

            odsc_pkg::S_CLK1:
            begin
                link_we    = 1'b1;
                link_waddr = cl_reg;
                link_wdata = linkq_reg;
                state_next = odsc_pkg::S_CLK2;
            end

            odsc_pkg::S_CLK2:
            begin
                link_we      = 1'b1;
                link_waddr   = q_reg;
                link_wdata   = cl_reg;
                linkcur_next = cl_reg;
                state_next   = odsc_pkg::S_RRD;
            end

            odsc_pkg::S_RRD:
            begin
                state_next = odsc_pkg::S_RCHK;
            end

            // redirect transitions that led to q onto the clone
            odsc_pkg::S_RCHK:
            begin
                if (tr_rdata != q_reg)
                begin
                    state_next = odsc_pkg::S_FIN0;
                end
                else
                begin
                    tr_we    = 1'b1;
                    tr_wdata = cl_reg;
                    if (p_reg == '0)
                    begin
                        state_next = odsc_pkg::S_FIN0;
                    end
                    else
                    begin
                        p_next     = link_rdata;
                        state_next = odsc_pkg::S_RRD;
                    end
                end
            end

            odsc_pkg::S_FIN0:
            begin
                link_we    = 1'b1;
                link_waddr = cur_reg;
                link_wdata = linkcur_reg;
                len_raddr  = linkcur_reg;
                state_next = odsc_pkg::S_FIN1;
            end

            odsc_pkg::S_FIN1:
            begin
                sum_next   = sum_reg + odsc_pkg::COUNT_W'(lencur_reg - len_rdata);
                last_next  = cur_reg;
                held_next  = held_reg + odsc_pkg::HELD_W'(1);
                state_next = odsc_pkg::S_IDLE;
            end

            default:
            begin
                state_next = odsc_pkg::S_IDLE;
            end
        endcase
    end

endmodule

>>> test/tb_online_distinct_substring_counter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_online_distinct_substring_counter_unit
// Drives letter appends, queries, restarts and ignored items into the
// substring counter. A suffix automaton inside the bench predicts each query
// result; results are checked in order against the predicted counts.
// ----------------------------------------------------------------------------
module tb_online_distinct_substring_counter_unit;

    localparam int CYCLE_LIMIT = 6000000;

    typedef struct {
        logic [odsc_pkg::COUNT_W-1:0] count;
        logic                         drop;
    } count_result_t;

    logic                         clk;
    logic                         rst_n;
    logic                         start;
    logic                         busy;
    logic [odsc_pkg::ACT_W-1:0]   action;
    logic [odsc_pkg::LET_W-1:0]   letter;
    logic                         done;
    logic [odsc_pkg::COUNT_W-1:0] distinct_count;
    logic                         dropped;

    online_distinct_substring_counter_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .action         (action),
        .letter         (letter),
        .done           (done),
        .distinct_count (distinct_count),
        .dropped        (dropped)
    );

    // shadow automaton
    int unsigned   sa_len [odsc_pkg::NODE_CAP];
    int unsigned   sa_link [odsc_pkg::NODE_CAP];
    int unsigned   sa_next [odsc_pkg::NODE_CAP * odsc_pkg::ALPHA];
    int unsigned   sa_nodes;
    int unsigned   sa_last;
    int unsigned   sa_total;
    int unsigned   sa_held;
    bit            sa_overflow;

    count_result_t pending_counts[$];
    int            idle_pct;
    bit            failed;
    longint        cycle_count;

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic int unsigned sa_make(int unsigned len);
        int unsigned n;
        n = sa_nodes;
        sa_nodes++;
        sa_len[n]  = len;
        sa_link[n] = 0;
        for (int i = 0; i < odsc_pkg::ALPHA; i++)
            sa_next[n * odsc_pkg::ALPHA + i] = 0;
        return n;
    endfunction

    function automatic void sa_clear();
        sa_nodes    = 0;
        void'(sa_make(0));
        sa_last     = 0;
        sa_total    = 0;
        sa_held     = 0;
        sa_overflow = 1'b0;
    endfunction

    function automatic void sa_extend(int unsigned ch);
        int unsigned cur, p, q, cl;
        bit          off_root;
        cur      = sa_make(sa_len[sa_last] + 1);
        p        = sa_last;
        off_root = 1'b0;
        forever
        begin
            if (sa_next[p * odsc_pkg::ALPHA + ch] != 0)
                break;
            sa_next[p * odsc_pkg::ALPHA + ch] = cur;
            if (p == 0)
            begin
                off_root = 1'b1;
                break;
            end
            p = sa_link[p];
        end
        if (!off_root)
        begin
            q = sa_next[p * odsc_pkg::ALPHA + ch];
            if (sa_len[p] + 1 == sa_len[q])
                sa_link[cur] = q;
            else
            begin
                cl = sa_make(sa_len[p] + 1);
                for (int i = 0; i < odsc_pkg::ALPHA; i++)
                    sa_next[cl * odsc_pkg::ALPHA + i] = sa_next[q * odsc_pkg::ALPHA + i];
                sa_link[cl]  = sa_link[q];
                sa_link[q]   = cl;
                sa_link[cur] = cl;
                forever
                begin
                    if (sa_next[p * odsc_pkg::ALPHA + ch] != q)
                        break;
                    sa_next[p * odsc_pkg::ALPHA + ch] = cl;
                    if (p == 0)
                        break;
                    p = sa_link[p];
                end
            end
        end
        sa_total = (sa_total + sa_len[cur] - sa_len[sa_link[cur]]) & 24'hFFFFFF;
        sa_last  = cur;
        sa_held++;
    endfunction

    // apply one accepted item to the shadow state
    function automatic void sa_apply(odsc_pkg::action_t act,
                                     logic [odsc_pkg::LET_W-1:0] let_idx);
        count_result_t r;
        case (act)
            odsc_pkg::ACT_APPEND:
            begin
                if (let_idx < odsc_pkg::ALPHA)
                begin
                    if (sa_held >= odsc_pkg::MAX_CHARS)
                        sa_overflow = 1'b1;
                    else
                        sa_extend(let_idx);
                end
            end
            odsc_pkg::ACT_QUERY:
            begin
                r.count = sa_total[odsc_pkg::COUNT_W-1:0];
                r.drop  = sa_overflow;
                pending_counts.push_back(r);
            end
            odsc_pkg::ACT_RESTART:
                sa_clear();
            default:
                ;
        endcase
    endfunction

    task automatic send_item(odsc_pkg::action_t act, logic [odsc_pkg::LET_W-1:0] let_idx);
        bit ready;
        int gap;
        start  <= 1'b1;
        action <= act;
        letter <= let_idx;
        do
        begin
            @(negedge clk);
            ready = !busy;
            @(posedge clk);
        end
        while (!ready);
        sa_apply(act, let_idx);
        gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 6) : 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    always @(negedge clk)
    begin
        count_result_t want;
        if (rst_n && done)
        begin
            if (pending_counts.size() == 0)
            begin
                $display("%0t: unexpected result count=%0d dropped=%0b",
                         $time, distinct_count, dropped);
                failed = 1'b1;
            end
            else
            begin
                want = pending_counts.pop_front();
                if (distinct_count !== want.count)
                begin
                    $display("%0t: distinct_count expected %0d actual %0d",
                             $time, want.count, distinct_count);
                    failed = 1'b1;
                end
                if (dropped !== want.drop)
                begin
                    $display("%0t: dropped expected %0b actual %0b",
                             $time, want.drop, dropped);
                    failed = 1'b1;
                end
            end
        end
    end

    task automatic test_directed();
        int pattern [10] = '{0, 1, 0, 1, 1, 0, 1, 0, 0, 0};
        idle_pct = 0;
        send_item(odsc_pkg::ACT_QUERY, 5'd0);
        send_item(odsc_pkg::ACT_APPEND, 5'd0);
        send_item(odsc_pkg::ACT_APPEND, 5'd25);
        send_item(odsc_pkg::ACT_QUERY, 5'd31);
        // out-of-range letters and the unused action leave state alone
        send_item(odsc_pkg::ACT_APPEND, 5'd26);
        send_item(odsc_pkg::ACT_APPEND, 5'd31);
        send_item(odsc_pkg::ACT_NONE, 5'd3);
        send_item(odsc_pkg::ACT_NONE, 5'd31);
        send_item(odsc_pkg::ACT_QUERY, 5'd0);
        // repeated patterns force clones
        foreach (pattern[i])
            send_item(odsc_pkg::ACT_APPEND, odsc_pkg::LET_W'(pattern[i]));
        send_item(odsc_pkg::ACT_QUERY, 5'd0);
        send_item(odsc_pkg::ACT_RESTART, 5'd31);
        send_item(odsc_pkg::ACT_QUERY, 5'd0);
    endtask

    task automatic test_capacity();
        idle_pct = 16;
        send_item(odsc_pkg::ACT_RESTART, 5'd0);
        for (int i = 0; i < odsc_pkg::MAX_CHARS; i++)
            send_item(odsc_pkg::ACT_APPEND, odsc_pkg::LET_W'($urandom_range(2)));
        send_item(odsc_pkg::ACT_QUERY, 5'd0);
        send_item(odsc_pkg::ACT_APPEND, 5'd25);
        send_item(odsc_pkg::ACT_QUERY, 5'd0);
        send_item(odsc_pkg::ACT_APPEND, 5'd1);
        send_item(odsc_pkg::ACT_QUERY, 5'd0);
        send_item(odsc_pkg::ACT_RESTART, 5'd0);
        send_item(odsc_pkg::ACT_QUERY, 5'd0);
    endtask

    task automatic test_random_stream(int pct, int n_items);
        int                pick;
        int                span;
        odsc_pkg::action_t act;
        idle_pct = pct;
        span     = 2;
        for (int i = 0; i < n_items; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
            begin
                // narrow alphabets give many clones
                if ($urandom_range(19) == 0)
                    span = $urandom_range(1, 3) == 1 ? odsc_pkg::ALPHA - 1
                                                     : $urandom_range(1, 3);
                send_item(odsc_pkg::ACT_APPEND, odsc_pkg::LET_W'($urandom_range(span)));
            end
            else if (pick < 90)
                send_item(odsc_pkg::ACT_QUERY, odsc_pkg::LET_W'($urandom_range(31)));
            else if (pick < 94)
                send_item(odsc_pkg::ACT_RESTART, odsc_pkg::LET_W'($urandom_range(31)));
            else
            begin
                act = $urandom_range(1) ? odsc_pkg::ACT_NONE : odsc_pkg::ACT_APPEND;
                send_item(act, act == odsc_pkg::ACT_APPEND
                               ? odsc_pkg::LET_W'($urandom_range(26, 31))
                               : odsc_pkg::LET_W'($urandom_range(31)));
            end
        end
    endtask

    initial
    begin
        failed      = 1'b0;
        cycle_count = 0;
        idle_pct    = 0;
        rst_n       = 1'b0;
        start       = 1'b0;
        action      = odsc_pkg::ACT_NONE;
        letter      = '0;
        sa_clear();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_random_stream(0, 300);
        test_random_stream(58, 300);
        test_capacity();
        test_random_stream(0, 300);
        test_random_stream(16, 300);

        // drop start at the edge of the last transfer so it is not taken twice
        start <= 1'b0;
        @(posedge clk);
        while (pending_counts.size() != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
        if (!failed)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
